[sv/tsad_pkg.sv]
// Package for the Type-C source attach detector.
// Holds the channel payload types, state and code enums, and the line classifier.
// Depends on nothing.
`default_nettype none

package tsad_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIndexW = 8;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] AttachDebounceReset = 8'd25;
  localparam logic [CountW-1:0] DetachDebounceReset = 8'd3;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ATTACH_DEBOUNCE = 8'd0,
    CFG_DETACH_DEBOUNCE = 8'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    LINE_OPEN = 2'd0,
    LINE_RD   = 2'd1,
    LINE_RA   = 2'd2
  } line_class_t;

  typedef enum logic [1:0] {
    CC_NONE = 2'd0,
    CC_ONE  = 2'd1,
    CC_TWO  = 2'd2
  } active_cc_t;

  typedef enum logic {
    CONN_DISCONNECTED = 1'b0,
    CONN_ATTACHED     = 1'b1
  } conn_state_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ATTACH   = 2'd1,
    EV_DETACH   = 2'd2,
    EV_OVERCURR = 2'd3
  } event_code_t;

  typedef enum logic {
    ACT_TICK     = 1'b0,
    ACT_OVERCURR = 1'b1
  } action_t;

  typedef struct packed {
    logic action;
    logic cc1_above_low;
    logic cc1_above_mid;
    logic cc1_above_high;
    logic cc2_above_low;
    logic cc2_above_mid;
    logic cc2_above_high;
  } sample_t;

  typedef struct packed {
    logic       attached;
    logic [1:0] active_line;
    logic       switch_on;
    logic       fault;
    logic [1:0] event_code;
  } status_t;

  typedef struct packed {
    logic [CountW-1:0] attach_debounce;
    logic [CountW-1:0] detach_debounce;
  } cfg_regs_t;

  function automatic line_class_t classify_line(input logic low, input logic mid,
                                                input logic high);
    line_class_t cls;
    if (high) begin
      cls = LINE_OPEN;
    end else if (mid) begin
      cls = LINE_RD;
    end else if (low) begin
      cls = LINE_RA;
    end else begin
      cls = LINE_OPEN;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

[sv/tsad_ifs.sv]
// Valid/ready channel interfaces for the Type-C source attach detector.
// Depends on tsad_pkg for the payload types.
`default_nettype none

interface tsad_sample_if;
  logic              valid;
  logic              ready;
  tsad_pkg::sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsad_status_if;
  logic              valid;
  logic              ready;
  tsad_pkg::status_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsad_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tsad_pkg::CfgIndexW-1:0]      index;
  logic [tsad_pkg::CountW-1:0]         data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/tsad_cfg_regs.sv]
// Debounce configuration registers of the Type-C source attach detector.
// Depends on tsad_pkg and the tsad_cfg_if interface.
`default_nettype none

module tsad_cfg_regs (
  input  wire                 clk,
  input  wire                 rst,
  tsad_cfg_if.sink            cfg,
  output tsad_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.attach_debounce <= tsad_pkg::AttachDebounceReset;
      regs.detach_debounce <= tsad_pkg::DetachDebounceReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        tsad_pkg::CFG_ATTACH_DEBOUNCE: regs.attach_debounce <= cfg.data;
        tsad_pkg::CFG_DETACH_DEBOUNCE: regs.detach_debounce <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/tsad_core.sv]
// Connection state and debounce update of the Type-C source attach detector.
// Holds the state registers and computes one status per transaction.
// Depends on tsad_pkg.
`default_nettype none

module tsad_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 step,
  input  tsad_pkg::sample_t   sample,
  input  tsad_pkg::cfg_regs_t regs,
  output tsad_pkg::status_t   status
);

  tsad_pkg::conn_state_t       conn_state, conn_state_next;
  tsad_pkg::active_cc_t        active_cc, active_cc_next;
  logic [tsad_pkg::CountW-1:0] debounce_count, debounce_count_next;
  logic                        fault_latched, fault_latched_next;
  logic                        switch_state, switch_state_next;

  tsad_pkg::line_class_t       c1, c2, act;
  tsad_pkg::active_cc_t        cand;
  tsad_pkg::event_code_t       event_code;
  logic [tsad_pkg::CountW-1:0] bumped;

  always_comb begin
    c1 = tsad_pkg::classify_line(sample.cc1_above_low, sample.cc1_above_mid,
                                 sample.cc1_above_high);
    c2 = tsad_pkg::classify_line(sample.cc2_above_low, sample.cc2_above_mid,
                                 sample.cc2_above_high);
    act = (active_cc == tsad_pkg::CC_ONE) ? c1 : c2;
    if (c1 == tsad_pkg::LINE_RD) begin
      cand = tsad_pkg::CC_ONE;
    end else if (c2 == tsad_pkg::LINE_RD) begin
      cand = tsad_pkg::CC_TWO;
    end else begin
      cand = tsad_pkg::CC_NONE;
    end
    bumped = (debounce_count == tsad_pkg::CountMax) ? debounce_count
                                                     : debounce_count + 1'b1;

    conn_state_next     = conn_state;
    active_cc_next      = active_cc;
    debounce_count_next = debounce_count;
    fault_latched_next  = fault_latched;
    switch_state_next   = switch_state;
    event_code          = tsad_pkg::EV_NONE;

    if (sample.action == tsad_pkg::ACT_OVERCURR) begin
      switch_state_next  = 1'b0;
      fault_latched_next = 1'b1;
      event_code         = tsad_pkg::EV_OVERCURR;
    end else if (conn_state == tsad_pkg::CONN_DISCONNECTED) begin
      if (cand != tsad_pkg::CC_NONE) begin
        debounce_count_next = bumped;
        if (bumped >= regs.attach_debounce) begin
          debounce_count_next = '0;
          active_cc_next      = cand;
          conn_state_next     = tsad_pkg::CONN_ATTACHED;
          if (!fault_latched) begin
            switch_state_next = 1'b1;
          end
          event_code = tsad_pkg::EV_ATTACH;
        end
      end else begin
        debounce_count_next = '0;
      end
    end else begin
      if (act != tsad_pkg::LINE_RD) begin
        debounce_count_next = bumped;
        if (bumped >= regs.detach_debounce) begin
          debounce_count_next = '0;
          switch_state_next   = 1'b0;
          active_cc_next      = tsad_pkg::CC_NONE;
          conn_state_next     = tsad_pkg::CONN_DISCONNECTED;
          event_code          = tsad_pkg::EV_DETACH;
        end
      end else begin
        debounce_count_next = '0;
      end
    end

    status.attached    = conn_state_next;
    status.active_line = active_cc_next;
    status.switch_on   = switch_state_next;
    status.fault       = fault_latched_next;
    status.event_code  = event_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state     <= tsad_pkg::CONN_DISCONNECTED;
      active_cc      <= tsad_pkg::CC_NONE;
      debounce_count <= '0;
      fault_latched  <= 1'b0;
      switch_state   <= 1'b0;
    end else if (step) begin
      conn_state     <= conn_state_next;
      active_cc      <= active_cc_next;
      debounce_count <= debounce_count_next;
      fault_latched  <= fault_latched_next;
      switch_state   <= switch_state_next;
    end
  end

endmodule

`default_nettype wire

[sv/typec_source_attach_detect.sv]
// USB Type-C source attach/detach detector with load-switch control.
//
// Channels: "sample" carries one detection tick or over-current event per
// transaction; "status" returns exactly one status transaction for each
// sample, showing attach state, active CC line, switch drive, latched fault
// and the event that the sample caused. "cfg" writes the attach and detach
// debounce counts; it is always ready and should be written only while no
// sample is in flight.
// A sample is captured in an input register, its update is computed
// combinationally against the state registers, and the status leaves from an
// output register. Throughput is one sample per cycle while the status
// receiver is ready.
// When the status receiver stalls, the output register holds its transaction
// and the input register holds the next sample; sample.ready drops only when
// both are occupied and the receiver is still stalling.
// Reset (rst, synchronous) empties both registers, returns the detector to
// disconnected with the switch off and the fault clear, and loads the debounce
// counts with 25 and 3.
// Depends on tsad_pkg, tsad_ifs, tsad_cfg_regs and tsad_core.
`default_nettype none

module typec_source_attach_detect (
  input  wire         clk,
  input  wire         rst,
  tsad_sample_if.sink sample,
  tsad_status_if.source status,
  tsad_cfg_if.sink    cfg
);

  tsad_pkg::cfg_regs_t regs;
  tsad_pkg::sample_t   sample_q;
  tsad_pkg::status_t   result;
  logic                in_full;
  logic                out_full;
  logic                advance;

  assign advance      = in_full && (!out_full || status.ready);
  assign sample.ready = !in_full || advance;
  assign status.valid = out_full;

  tsad_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tsad_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (sample_q),
    .regs   (regs),
    .status (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (status.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      sample_q <= sample.data;
    end
    if (advance) begin
      status.data <= result;
    end
  end

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for typec_source_attach_detect: detection ticks and over-current events are sent
// while a behavioral model of the detector predicts each status transaction for comparison.
// Depends on tsad_pkg, tsad_ifs and the detector RTL.

module tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned MaxWait = 18;

  // Comparator patterns ordered as {above_low, above_mid, above_high}.
  localparam logic [2:0] CmpNone = 3'b000;
  localparam logic [2:0] CmpRa = 3'b100;
  localparam logic [2:0] CmpRd = 3'b110;
  localparam logic [2:0] CmpMidOnly = 3'b010;
  localparam logic [2:0] CmpHighMid = 3'b011;
  localparam logic [2:0] CmpOpen = 3'b111;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsad_sample_if sample_ch();
  tsad_status_if status_ch();
  tsad_cfg_if cfg_ch();

  typec_source_attach_detect dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .status(status_ch),
    .cfg(cfg_ch)
  );

  logic [tsad_pkg::CountW-1:0] attach_len;
  logic [tsad_pkg::CountW-1:0] detach_len;
  logic [tsad_pkg::CountW-1:0] run_len;
  tsad_pkg::conn_state_t link;
  tsad_pkg::active_cc_t line_sel;
  logic sw_on;
  logic fault_seen;

  tsad_pkg::status_t pending_status[$];
  tsad_pkg::status_t exp_status;
  tsad_pkg::status_t dut_status;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic tsad_pkg::line_class_t sense_line(logic [2:0] cmp);
    if (cmp[0]) return tsad_pkg::LINE_OPEN;
    if (cmp[1]) return tsad_pkg::LINE_RD;
    if (cmp[2]) return tsad_pkg::LINE_RA;
    return tsad_pkg::LINE_OPEN;
  endfunction

  function automatic tsad_pkg::status_t advance_detector(tsad_pkg::sample_t s);
    tsad_pkg::status_t r;
    tsad_pkg::line_class_t c1;
    tsad_pkg::line_class_t c2;
    tsad_pkg::line_class_t on_active;
    tsad_pkg::active_cc_t cand;
    tsad_pkg::event_code_t ev;
    ev = tsad_pkg::EV_NONE;
    c1 = sense_line({s.cc1_above_low, s.cc1_above_mid, s.cc1_above_high});
    c2 = sense_line({s.cc2_above_low, s.cc2_above_mid, s.cc2_above_high});
    if (s.action == tsad_pkg::ACT_OVERCURR) begin
      sw_on = 1'b0;
      fault_seen = 1'b1;
      ev = tsad_pkg::EV_OVERCURR;
    end else if (link == tsad_pkg::CONN_DISCONNECTED) begin
      cand = (c1 == tsad_pkg::LINE_RD) ? tsad_pkg::CC_ONE :
             ((c2 == tsad_pkg::LINE_RD) ? tsad_pkg::CC_TWO : tsad_pkg::CC_NONE);
      if (cand != tsad_pkg::CC_NONE) begin
        if (run_len != tsad_pkg::CountMax) run_len = run_len + 1'b1;
        if (run_len >= attach_len) begin
          run_len = '0;
          line_sel = cand;
          link = tsad_pkg::CONN_ATTACHED;
          if (!fault_seen) sw_on = 1'b1;
          ev = tsad_pkg::EV_ATTACH;
        end
      end else begin
        run_len = '0;
      end
    end else begin
      on_active = (line_sel == tsad_pkg::CC_ONE) ? c1 : c2;
      if (on_active != tsad_pkg::LINE_RD) begin
        if (run_len != tsad_pkg::CountMax) run_len = run_len + 1'b1;
        if (run_len >= detach_len) begin
          run_len = '0;
          sw_on = 1'b0;
          line_sel = tsad_pkg::CC_NONE;
          link = tsad_pkg::CONN_DISCONNECTED;
          ev = tsad_pkg::EV_DETACH;
        end
      end else begin
        run_len = '0;
      end
    end
    r.attached = link;
    r.active_line = line_sel;
    r.switch_on = sw_on;
    r.fault = fault_seen;
    r.event_code = ev;
    return r;
  endfunction

  function automatic string fmt_status(tsad_pkg::status_t s);
    return $sformatf("attached=%0d line=%0d switch=%0d fault=%0d event=%0d",
                     s.attached, s.active_line, s.switch_on, s.fault, s.event_code);
  endfunction

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= ReportLimit) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && status_ch.valid && status_ch.ready) begin
      dut_status = status_ch.data;
      if (pending_status.size() == 0) begin
        flag_error({"unexpected status transaction: ", fmt_status(dut_status)});
      end else begin
        exp_status = pending_status.pop_front();
        if (dut_status.attached !== exp_status.attached ||
            dut_status.active_line !== exp_status.active_line ||
            dut_status.switch_on !== exp_status.switch_on ||
            dut_status.fault !== exp_status.fault ||
            dut_status.event_code !== exp_status.event_code) begin
          flag_error({"status mismatch: expected ", fmt_status(exp_status),
                      " actual ", fmt_status(dut_status)});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : status_sink
    int unsigned stall;
    status_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, MaxWait) : 0;
      @(negedge clk);
      if (stall != 0) begin
        status_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      status_ch.ready <= 1'b1;
      @(posedge clk);
      while (!status_ch.valid) @(posedge clk);
    end
  end

  function automatic logic [2:0] any_bits();
    logic [2:0] b;
    b = 3'($urandom_range(0, 7));
    return b;
  endfunction

  function automatic logic [2:0] rd_bits();
    logic low;
    low = 1'($urandom_range(0, 1));
    return {low, 2'b10};
  endfunction

  function automatic logic [2:0] non_rd_bits();
    logic [2:0] b;
    b = 3'($urandom_range(0, 7));
    if (b[1:0] == 2'b10) b[1] = 1'b0;
    return b;
  endfunction

  function automatic tsad_pkg::sample_t make_tick(logic [2:0] c1, logic [2:0] c2);
    tsad_pkg::sample_t s;
    s.action = tsad_pkg::ACT_TICK;
    {s.cc1_above_low, s.cc1_above_mid, s.cc1_above_high} = c1;
    {s.cc2_above_low, s.cc2_above_mid, s.cc2_above_high} = c2;
    return s;
  endfunction

  function automatic tsad_pkg::sample_t random_item(bit allow_oc);
    tsad_pkg::sample_t s;
    s = make_tick(any_bits(), any_bits());
    if (allow_oc && $urandom_range(0, 11) == 0) s.action = tsad_pkg::ACT_OVERCURR;
    return s;
  endfunction

  task automatic send_sample(tsad_pkg::sample_t s);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MaxWait) : 0;
    @(negedge clk);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_status.push_back(advance_detector(s));
  endtask

  task automatic tick(logic [2:0] c1, logic [2:0] c2);
    send_sample(make_tick(c1, c2));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(tsad_pkg::cfg_index_t idx, logic [tsad_pkg::CountW-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == tsad_pkg::CFG_ATTACH_DEBOUNCE) begin
      attach_len = val;
    end else begin
      detach_len = val;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Runs of Rd while disconnected and runs of non-Rd on the active line while
  // attached, with lengths clustered around the current debounce count, or one random item.
  task automatic send_burst(bit allow_oc, inout int unsigned sent);
    int unsigned thr;
    int unsigned len;
    int unsigned pick;
    if ($urandom_range(0, 9) == 0) begin
      send_sample(random_item(allow_oc));
      sent++;
    end else if (link == tsad_pkg::CONN_DISCONNECTED) begin
      thr = (attach_len == 0) ? 1 : attach_len;
      len = ($urandom_range(0, 9) < 7) ? thr + $urandom_range(0, 2) : $urandom_range(1, thr);
      pick = $urandom_range(0, 2);
      repeat (len) begin
        case (pick)
          0: tick(rd_bits(), any_bits());
          1: tick(non_rd_bits(), rd_bits());
          default: tick(rd_bits(), rd_bits());
        endcase
      end
      sent += len;
    end else begin
      thr = (detach_len == 0) ? 1 : detach_len;
      len = ($urandom_range(0, 9) < 7) ? thr + $urandom_range(0, 2) : $urandom_range(1, thr);
      repeat (len) begin
        if (line_sel == tsad_pkg::CC_ONE) begin
          tick(non_rd_bits(), any_bits());
        end else begin
          tick(any_bits(), non_rd_bits());
        end
      end
      sent += len;
      if (len < thr && $urandom_range(0, 1) == 1) begin
        if (line_sel == tsad_pkg::CC_ONE) begin
          tick(rd_bits(), any_bits());
        end else begin
          tick(any_bits(), rd_bits());
        end
        sent++;
      end
    end
  endtask

  task automatic test_reset_debounce();
    tick(CmpRd, CmpNone);
    tick(CmpRa, CmpOpen);
    repeat (12) tick(rd_bits(), non_rd_bits());
    repeat (11) tick(non_rd_bits(), rd_bits());
    tick(CmpMidOnly, CmpRd);
    tick(CmpRd, CmpRd);
    tick(CmpRa, CmpRd);
    tick(CmpHighMid, CmpNone);
    tick(CmpRd, CmpOpen);
    tick(CmpNone, CmpRd);
    tick(CmpOpen, CmpRd);
    tick(CmpRa, CmpRa);
  endtask

  task automatic test_zero_debounce();
    write_reg(tsad_pkg::CFG_ATTACH_DEBOUNCE, 8'd0);
    write_reg(tsad_pkg::CFG_DETACH_DEBOUNCE, 8'd0);
    tick(CmpNone, CmpRd);
    tick(CmpRa, CmpMidOnly);
    tick(CmpRd, CmpHighMid);
    tick(CmpRd, CmpNone);
    tick(CmpNone, CmpRd);
  endtask

  task automatic test_random_traffic();
    int unsigned att_val [7] = '{1, 255, 0, 0, 255, 7, 25};
    int unsigned det_val [7] = '{1, 255, 0, 0, 1, 255, 3};
    int unsigned budget [7] = '{100, 330, 60, 160, 180, 200, 120};
    bit tx_mode [7] = '{0, 1, 1, 0, 1, 0, 1};
    bit rx_mode [7] = '{0, 1, 0, 1, 1, 0, 1};
    int unsigned sent;
    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        write_reg(tsad_pkg::CFG_ATTACH_DEBOUNCE, 8'($urandom_range(2, 40)));
        write_reg(tsad_pkg::CFG_DETACH_DEBOUNCE, 8'($urandom_range(2, 40)));
      end else begin
        write_reg(tsad_pkg::CFG_ATTACH_DEBOUNCE, 8'(att_val[p]));
        write_reg(tsad_pkg::CFG_DETACH_DEBOUNCE, 8'(det_val[p]));
      end
      tx_idle = tx_mode[p];
      rx_idle = rx_mode[p];
      sent = 0;
      while (sent < budget[p]) send_burst(1'b0, sent);
    end
  endtask

  // The fault stays latched until reset, so this runs last.
  task automatic test_overcurrent();
    tsad_pkg::sample_t s;
    int unsigned sent;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_reg(tsad_pkg::CFG_ATTACH_DEBOUNCE, 8'd1);
    write_reg(tsad_pkg::CFG_DETACH_DEBOUNCE, 8'd1);
    if (link == tsad_pkg::CONN_ATTACHED) tick(CmpOpen, CmpOpen);
    s = make_tick(any_bits(), any_bits());
    s.action = tsad_pkg::ACT_OVERCURR;
    send_sample(s);
    tick(CmpRd, CmpNone);
    s = make_tick(CmpRd, CmpRd);
    s.action = tsad_pkg::ACT_OVERCURR;
    send_sample(s);
    tick(CmpRa, CmpRd);
    tick(CmpNone, CmpRd);
    sent = 0;
    while (sent < 120) send_burst(1'b1, sent);
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tsad_pkg::CFG_ATTACH_DEBOUNCE;
    cfg_ch.data = '0;
    attach_len = tsad_pkg::AttachDebounceReset;
    detach_len = tsad_pkg::DetachDebounceReset;
    run_len = '0;
    link = tsad_pkg::CONN_DISCONNECTED;
    line_sel = tsad_pkg::CC_NONE;
    sw_on = 1'b0;
    fault_seen = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_reset_debounce();
    test_zero_debounce();
    test_random_traffic();
    test_overcurrent();
    wait_idle();
    repeat (4) @(posedge clk);
    if (err_count == 0 && pending_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tsad_pkg.sv
sv/tsad_ifs.sv
sv/tsad_cfg_regs.sv
sv/tsad_core.sv
sv/typec_source_attach_detect.sv
test/tb.sv
